>>> rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the utf-8 to utf-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

	// byte class limits
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MIN  = 8'h80;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	// code point limits
	localparam logic [20:0] SURR_MIN  = 21'h00D800;
	localparam logic [20:0] SURR_MAX  = 21'h00DFFF;
	localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;
	localparam logic [20:0] SUPP_BASE = 21'h010000;

	// surrogate bases
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

	// command kinds handed from front to back
	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_PAIR   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [20:0] cp;
		logic        last;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: assembles code points and classifies them into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     take,
	input  wire [7:0]               byte_in,
	input  wire                     end_of_string,
	output logic                    cmd_valid,
	output u8u16_pkg::cmd_t         cmd
);

	logic [20:0] partial_q;
	logic [1:0]  remaining_q;
	logic        discarding_q;

	logic [20:0] partial_d;
	logic [1:0]  remaining_d;
	logic        discarding_d;

	logic        fail_v;
	logic        emit_v;
	logic [20:0] cp_v;
	logic [20:0] acc;
	logic [1:0]  rem_dec;
	logic        bad_cp;

	assign acc     = {partial_q[14:0], byte_in[5:0]};
	assign rem_dec = remaining_q - 2'd1;

	always_comb begin
		fail_v       = 1'b0;
		emit_v       = 1'b0;
		cp_v         = '0;
		partial_d    = partial_q;
		remaining_d  = remaining_q;
		discarding_d = discarding_q;
		cmd_valid    = 1'b0;
		cmd          = '0;

		if (remaining_q == 2'd0) begin
			priority if (byte_in <= u8u16_pkg::ASCII_MAX) begin
				emit_v = 1'b1;
				cp_v   = {13'd0, byte_in};
			end else if (byte_in <= u8u16_pkg::CONT_MAX) begin
				fail_v = 1'b1;
			end else if (byte_in <= u8u16_pkg::LEAD2_MAX) begin
				partial_d   = {16'd0, byte_in[4:0]};
				remaining_d = 2'd1;
				fail_v      = end_of_string;
			end else if (byte_in <= u8u16_pkg::LEAD3_MAX) begin
				partial_d   = {17'd0, byte_in[3:0]};
				remaining_d = 2'd2;
				fail_v      = end_of_string;
			end else if (byte_in <= u8u16_pkg::LEAD4_MAX) begin
				partial_d   = {18'd0, byte_in[2:0]};
				remaining_d = 2'd3;
				fail_v      = end_of_string;
			end else begin
				fail_v = 1'b1;
			end
		end else if (byte_in < u8u16_pkg::CONT_MIN || byte_in > u8u16_pkg::CONT_MAX) begin
			fail_v = 1'b1;
		end else if (rem_dec != 2'd0) begin
			partial_d   = acc;
			remaining_d = rem_dec;
			fail_v      = end_of_string;
		end else begin
			emit_v = 1'b1;
			cp_v   = acc;
		end

		bad_cp = (cp_v >= u8u16_pkg::SURR_MIN && cp_v <= u8u16_pkg::SURR_MAX)
			|| (cp_v > u8u16_pkg::CP_MAX);

		if (discarding_q) begin
			// string already failed: swallow bytes until the end mark
			if (end_of_string) begin
				cmd_valid    = 1'b1;
				cmd.kind     = u8u16_pkg::KIND_ERROR;
				cmd.last     = 1'b1;
				partial_d    = '0;
				remaining_d  = 2'd0;
				discarding_d = 1'b0;
			end else begin
				partial_d   = partial_q;
				remaining_d = remaining_q;
			end
		end else if (fail_v || (emit_v && bad_cp)) begin
			partial_d   = '0;
			remaining_d = 2'd0;
			if (end_of_string) begin
				cmd_valid = 1'b1;
				cmd.kind  = u8u16_pkg::KIND_ERROR;
				cmd.last  = 1'b1;
			end else begin
				discarding_d = 1'b1;
			end
		end else if (emit_v) begin
			cmd_valid   = 1'b1;
			cmd.kind    = (cp_v > u8u16_pkg::BMP_MAX) ? u8u16_pkg::KIND_PAIR
				: u8u16_pkg::KIND_SINGLE;
			cmd.cp      = cp_v;
			cmd.last    = end_of_string;
			partial_d   = '0;
			remaining_d = 2'd0;
		end

		if (!take) begin
			cmd_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			remaining_q  <= 2'd0;
			discarding_q <= 1'b0;
		end else if (take) begin
			partial_q    <= partial_d;
			remaining_q  <= remaining_d;
			discarding_q <= discarding_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/u8u16_cmd_fifo.sv
// ----------------------------------------------------------------------------
// u8u16_cmd_fifo
// Small command queue between decoder and unit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  wire u8u16_pkg::cmd_t    push_cmd,
	input  wire                     pop,
	output logic                    full,
	output logic                    empty,
	output u8u16_pkg::cmd_t         head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	u8u16_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Unit emitter: turns commands into utf-16 code units in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     head_valid,
	input  wire u8u16_pkg::cmd_t    head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [15:0]             code_unit,
	output logic                    error,
	output logic                    last_unit
);

	logic        valid_q;
	logic        low_half_q;
	logic [15:0] unit_q;
	logic        error_q;
	logic        last_q;

	logic        load;
	logic        is_pair;
	logic [20:0] supp;
	logic [15:0] unit_d;
	logic        error_d;
	logic        last_d;

	assign load    = head_valid && (!valid_q || !out_stall);
	assign is_pair = (head.kind == u8u16_pkg::KIND_PAIR);
	assign pop     = load && !(is_pair && !low_half_q);
	assign supp    = head.cp - u8u16_pkg::SUPP_BASE;

	always_comb begin
		unit_d  = '0;
		error_d = 1'b0;
		last_d  = head.last;
		unique case (head.kind)
			u8u16_pkg::KIND_SINGLE: unit_d = head.cp[15:0];
			u8u16_pkg::KIND_PAIR: begin
				if (low_half_q) begin
					unit_d = u8u16_pkg::LO_SURR_BASE | {6'd0, supp[9:0]};
				end else begin
					unit_d = u8u16_pkg::HI_SURR_BASE | {6'd0, supp[19:10]};
					last_d = 1'b0;
				end
			end
			u8u16_pkg::KIND_ERROR: error_d = 1'b1;
			default: unit_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			low_half_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q    <= 1'b1;
				low_half_q <= is_pair && !low_half_q;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q  <= unit_d;
			error_q <= error_d;
			last_q  <= last_d;
		end
	end

	assign out_valid = valid_q;
	assign code_unit = unit_q;
	assign error     = error_q;
	assign last_unit = last_q;

endmodule

`default_nettype wire

>>> rtl/core/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// UTF-8 byte stream in, UTF-16 code units out, one error beat per bad string.
// ----------------------------------------------------------------------------
// usage:
//  - input channel takes one byte beat per cycle (byte_in, end_of_string)
//    under in_valid / in_stall; a beat moves when valid is high, stall low
//  - output channel gives code unit beats (code_unit, error, last_unit)
//    under out_valid / out_stall, held stable while stalled
//  - throughput: one byte per cycle while the queue is not full; a
//    supplementary code point gives two output beats (high then low surrogate)
//  - a completing byte is decoded into the queue on the edge that accepts
//    its beat; its first unit is then loaded from the queue head into the
//    output register once that register is empty or not stalled
//  - the decoder pushes into a CMD_DEPTH entry command queue; in_stall is
//    high only while that queue is full, so the input keeps flowing while
//    the receiver stalls until the queue fills up
//  - a failed string produces no units after the failure; its end byte
//    gives one beat with error and last_unit set and code_unit zero
//  - reset (arst_n low) clears the decoder state, the queue and out_valid
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_core #(
	parameter int CMD_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  byte_in,
	input  wire         end_of_string,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] code_unit,
	output logic        error,
	output logic        last_unit
);

	// front to queue
	logic                 take;
	logic                 cmd_valid;
	u8u16_pkg::cmd_t      cmd;

	// queue to back
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	u8u16_pkg::cmd_t      q_head;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	// decoder: byte accumulation and validity checks
	u8u16_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.byte_in       (byte_in),
		.end_of_string (end_of_string),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd)
	);

	// decouples byte intake from unit emission
	u8u16_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_valid),
		.push_cmd (cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// emitter: surrogate split and output register
	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_unit  (code_unit),
		.error      (error),
		.last_unit  (last_unit)
	);

endmodule

`default_nettype wire

>>> dv/utf16_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_unit_checker
// Decodes every accepted utf-8 byte beat into the code unit beats it should
// give and compares them, in order, with the beats accepted at the output.
// ----------------------------------------------------------------------------

module utf16_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        end_of_string,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] code_unit,
	input  logic        error,
	input  logic        last_unit,
	output int          mismatches,
	output int          pending_units
);

	typedef struct packed {
		logic [15:0] unit;
		logic        err;
		logic        last;
	} unit_beat_t;

	unit_beat_t  expected_units[$];
	unit_beat_t  want;
	logic [20:0] partial_cp;
	logic [1:0]  conts_left;
	logic        discarding;
	int          fail_total;

	task automatic queue_unit(input logic [15:0] unit, input logic err, input logic last);
		expected_units.insert(expected_units.size(), {unit, err, last});
	endtask

	task automatic clear_string();
		partial_cp = '0;
		conts_left = '0;
		discarding = 1'b0;
	endtask

	// error beat right away on the end byte, otherwise drop the rest
	task automatic fail_string(input logic eos);
		if (eos) begin
			clear_string();
			queue_unit(16'h0000, 1'b1, 1'b1);
		end else begin
			partial_cp = '0;
			conts_left = '0;
			discarding = 1'b1;
		end
	endtask

	task automatic emit_code_point(input logic [20:0] cp, input logic eos);
		logic [20:0] offset;
		if ((cp >= u8u16_pkg::SURR_MIN && cp <= u8u16_pkg::SURR_MAX) ||
				cp > u8u16_pkg::CP_MAX) begin
			fail_string(eos);
		end else begin
			if (eos)
				clear_string();
			if (cp <= u8u16_pkg::BMP_MAX) begin
				queue_unit(cp[15:0], 1'b0, eos);
			end else begin
				offset = cp - u8u16_pkg::SUPP_BASE;
				queue_unit(u8u16_pkg::HI_SURR_BASE + {6'd0, offset[19:10]}, 1'b0, 1'b0);
				queue_unit(u8u16_pkg::LO_SURR_BASE + {6'd0, offset[9:0]}, 1'b0, eos);
			end
		end
	endtask

	task automatic decode_utf8_byte(input logic [7:0] b, input logic eos);
		logic [20:0] cp;
		if (discarding) begin
			if (eos)
				fail_string(1'b1);
		end else if (conts_left == 2'd0) begin
			if (b <= u8u16_pkg::ASCII_MAX) begin
				emit_code_point({13'd0, b}, eos);
			end else if (b <= u8u16_pkg::CONT_MAX || b > u8u16_pkg::LEAD4_MAX) begin
				fail_string(eos);
			end else begin
				if (b <= u8u16_pkg::LEAD2_MAX) begin
					partial_cp = {16'd0, b[4:0]};
					conts_left = 2'd1;
				end else if (b <= u8u16_pkg::LEAD3_MAX) begin
					partial_cp = {17'd0, b[3:0]};
					conts_left = 2'd2;
				end else begin
					partial_cp = {18'd0, b[2:0]};
					conts_left = 2'd3;
				end
				if (eos)
					fail_string(1'b1);
			end
		end else if (b < u8u16_pkg::CONT_MIN || b > u8u16_pkg::CONT_MAX) begin
			fail_string(eos);
		end else begin
			partial_cp = {partial_cp[14:0], b[5:0]};
			conts_left = conts_left - 2'd1;
			if (conts_left != 2'd0) begin
				if (eos)
					fail_string(1'b1);
			end else begin
				cp = partial_cp;
				partial_cp = '0;
				emit_code_point(cp, eos);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
			expected_units.delete();
			fail_total = 0;
			mismatches <= 0;
			pending_units <= 0;
		end else begin
			// outputs first: a byte never shows up on the same edge it goes in
			if (out_valid && !out_stall) begin
				if (expected_units.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: unexpected beat code_unit %h error %b last_unit %b",
							$time, code_unit, error, last_unit);
					fail_total++;
				end else begin
					want = expected_units.pop_front();
					if (code_unit !== want.unit || error !== want.err ||
							last_unit !== want.last) begin
						if (fail_total < 10)
							$display({"%0t: mismatch code_unit %h/%h error %b/%b",
								" last_unit %b/%b (got/want)"}, $time, code_unit,
								want.unit, error, want.err, last_unit, want.last);
						fail_total++;
					end
				end
			end
			if (in_valid && !in_stall)
				decode_utf8_byte(byte_in, end_of_string);
			mismatches <= fail_total;
			pending_units <= expected_units.size();
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives utf-8 strings into the transcoder under random input bursts and
// output stalls; a side checker predicts and compares the utf-16 beats.
// ----------------------------------------------------------------------------

module testbench;

	localparam int RANDOM_BYTES  = 1000;
	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        end_of_string;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] code_unit;
	logic        error;
	logic        last_unit;

	int mismatches;
	int pending_units;

	// bytes of the string being built; end mark goes on the last one
	logic [7:0] str_bytes[$];

	int burst_left  = 1;
	int bytes_sent  = 0;
	int holds_asked = 0;
	int holds_done  = 0;
	int idle_cycles = 0;

	utf8_to_utf16_transcoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_unit     (code_unit),
		.error         (error),
		.last_unit     (last_unit)
	);

	utf16_unit_checker unit_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_unit     (code_unit),
		.error         (error),
		.last_unit     (last_unit),
		.mismatches    (mismatches),
		.pending_units (pending_units)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// add one byte at the tail of the string
	function automatic void append_byte(input logic [7:0] b);
		str_bytes.insert(str_bytes.size(), b);
	endfunction

	// utf-8 encoding by magnitude only, so surrogates and values past the
	// unicode range come out as well-formed byte patterns too
	function automatic void push_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			append_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			append_byte({3'b110, cp[10:6]});
			append_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			append_byte({4'b1110, cp[15:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end else begin
			append_byte({5'b11110, cp[20:18]});
			append_byte({2'b10, cp[17:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end
	endfunction

	// one beat per byte; valid stays up across a burst and drops for a gap
	// when the burst runs out (sometimes the next burst follows directly)
	task automatic send_string();
		for (int i = 0; i < str_bytes.size(); i++) begin
			in_valid <= 1'b1;
			byte_in <= str_bytes[i];
			end_of_string <= (i == str_bytes.size() - 1);
			do @(posedge clk); while (in_stall);
			bytes_sent++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 48);
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
		end
	endtask

	// sender goes quiet until every predicted beat has come out
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_units != 0);
	endtask

	// receiver: stretches of no stall, light, even and heavy random stall,
	// and a long hold-off whenever the sender asks for one
	initial begin
		int mode;
		int seg;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			seg = $urandom_range(4, 40);
			repeat (seg) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// watchdog: a long run of cycles with no beat on either side ends it
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d units still due",
				idle_cycles, pending_units);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          string_idx;
		int          pick;
		int          span;
		logic [20:0] cp;
		logic [7:0]  raw;

		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		end_of_string = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		// ascii extremes
		str_bytes = '{8'h00, 8'h7F};
		send_string();
		// overlong two-byte nul is taken as is
		str_bytes = '{8'hC0, 8'h80};
		send_string();
		// top of the bmp, bottom and top of the supplementary planes;
		// the end mark lands on a surrogate pair
		str_bytes = '{8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_string();
		// surrogate code point completed on the end byte
		str_bytes = '{8'hED, 8'hA0, 8'h80};
		send_string();
		// value past 0x10ffff, then a discarded byte carrying the end mark
		str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'h41};
		send_string();
		// stray continuation as lead
		str_bytes = '{8'h80};
		send_string();
		// lead byte above the four-byte range
		str_bytes = '{8'hF8};
		send_string();
		// non-continuation where a continuation belongs
		str_bytes = '{8'hC2, 8'h41};
		send_string();
		// sequence cut off by the end of the string
		str_bytes = '{8'hE2, 8'h82};
		send_string();

		// random strings, mostly well formed with some broken ones mixed in
		string_idx = 0;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			str_bytes.delete();
			repeat ($urandom_range(1, 6)) begin
				pick = $urandom_range(0, 99);
				span = $urandom_range(0, 3);
				case (span)
					0: cp = 21'($urandom_range(0, 'h7F));
					1: cp = 21'($urandom_range('h80, 'h7FF));
					2: cp = 21'($urandom_range('h800, 'hFFFF));
					default: cp = 21'($urandom_range('h10000, 'h10FFFF));
				endcase
				if (pick < 80) begin
					// keep it a scalar value
					if (cp >= 21'hD800 && cp <= 21'hDFFF)
						cp = cp - 21'h800;
					push_utf8(cp);
				end else if (pick < 86) begin
					// surrogate or beyond the unicode range, cleanly encoded
					if ($urandom_range(0, 1) == 1)
						cp = 21'($urandom_range('hD800, 'hDFFF));
					else
						cp = 21'($urandom_range('h110000, 'h1FFFFF));
					push_utf8(cp);
				end else if (pick < 94) begin
					// any lead byte, then a few mostly-continuation bytes
					raw = 8'($urandom_range(0, 255));
					append_byte(raw);
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 3) == 0)
							raw = 8'($urandom_range(0, 255));
						else
							raw = 8'($urandom_range('h80, 'hBF));
						append_byte(raw);
					end
				end else begin
					// multi-byte sequence missing its last byte (an ascii pick stays whole)
					push_utf8(cp);
					if (span != 0)
						str_bytes.delete(str_bytes.size() - 1);
				end
			end
			send_string();
			string_idx++;
			// long receiver hold-off while bytes keep coming
			if (string_idx == 20 || string_idx == 75)
				holds_asked++;
			if (string_idx % 30 == 15)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_units == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
